// File: src/four_bus_i2c_master_sequencer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the four-bus I2C master sequencer
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef FOUR_BUS_I2C_MASTER_SEQUENCER_MACROS_SVH
`define FOUR_BUS_I2C_MASTER_SEQUENCER_MACROS_SVH

`ifndef SYNTHESIS
`define I2CMS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("i2cms: same-cycle check failed");
`define I2CMS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("i2cms: next-cycle check failed");
`else
`define I2CMS_ASSERT_SAME(label, ante, cons)
`define I2CMS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: src/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// I2C master sequencer package
// Beat types, sequencer state, phase and command codes, and reset constants.
// ----------------------------------------------------------------------------
package i2cms_pkg;

  localparam int unsigned BUS_COUNT = 4;
  localparam int unsigned LINE_W = 4;

  localparam logic [7:0] LIMIT_RESET = 8'd250;
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [2:0] {
    MODE_TICK     = 3'd0,
    MODE_START    = 3'd1,
    MODE_STOP     = 3'd2,
    MODE_SEND     = 3'd3,
    MODE_READ     = 3'd4,
    MODE_WAIT_ACK = 3'd5
  } mode_e;

  typedef enum logic [17:0] {
    PH_IDLE   = 18'h00001,
    PH_ST1    = 18'h00002,
    PH_ST2    = 18'h00004,
    PH_ST3    = 18'h00008,
    PH_ST4    = 18'h00010,
    PH_SP1    = 18'h00020,
    PH_SP2    = 18'h00040,
    PH_SP3    = 18'h00080,
    PH_TX_HI  = 18'h00100,
    PH_TX_LO  = 18'h00200,
    PH_TX_END = 18'h00400,
    PH_RX_LO  = 18'h00800,
    PH_RX_HI  = 18'h01000,
    PH_RX_SMP = 18'h02000,
    PH_AK1    = 18'h04000,
    PH_AK2    = 18'h08000,
    PH_AK3    = 18'h10000,
    PH_WA     = 18'h20000
  } phase_e;

  typedef struct packed {
    logic [2:0]        mode;
    logic [1:0]        bus_select;
    logic [7:0]        tx_byte;
    logic              give_ack;
    logic [LINE_W-1:0] sda_sampled;
  } item_t;

  typedef struct packed {
    logic [LINE_W-1:0] scl_lines;
    logic [LINE_W-1:0] sda_lines;
    logic [LINE_W-1:0] sda_enable;
    logic              busy_res;
    logic              done_res;
    logic [7:0]        rx_byte;
    logic              ack_timeout;
    logic              refused;
  } result_t;

  typedef struct packed {
    logic [LINE_W-1:0] scl;
    logic [LINE_W-1:0] sda;
    logic [LINE_W-1:0] drv;
    phase_e            phase;
    logic [2:0]        cmd;
    logic [1:0]        bus;
    logic [3:0]        bit_count;
    logic [7:0]        shift;
    logic [7:0]        wait_count;
    logic              ack_choice;
  } state_t;

  localparam state_t STATE_RESET = '{
    scl:        '1,
    sda:        '1,
    drv:        '1,
    phase:      PH_IDLE,
    cmd:        3'd0,
    bus:        2'd0,
    bit_count:  4'd0,
    shift:      8'd0,
    wait_count: 8'd0,
    ack_choice: 1'b0
  };

endpackage

// File: src/i2cms_step.sv
// ----------------------------------------------------------------------------
// I2C master sequencer step
// Next-state and result logic for one accepted tick or command beat.
// ----------------------------------------------------------------------------
module i2cms_step (
  input  i2cms_pkg::state_t  state_i,
  input  i2cms_pkg::item_t   item_i,
  input  logic [7:0]         limit_i,
  output i2cms_pkg::state_t  state_o,
  output i2cms_pkg::result_t result_o
);
  import i2cms_pkg::*;

  state_t     nxt;
  logic       samp_bit;
  logic       mode_ok;
  logic       adv_done;
  logic       done;
  logic       rx_valid;
  logic       timeout;
  logic       refused;
  logic [3:0] cnt_inc;

  assign samp_bit = item_i.sda_sampled[state_i.bus];
  assign mode_ok  = (item_i.mode <= MODE_WAIT_ACK);
  assign cnt_inc  = state_i.bit_count + 4'd1;

  always_comb begin
    nxt      = state_i;
    adv_done = 1'b0;
    done     = 1'b0;
    rx_valid = 1'b0;
    timeout  = 1'b0;
    refused  = 1'b0;
    if (mode_ok) begin
      if (state_i.phase != PH_IDLE) begin
        refused = (item_i.mode != MODE_TICK);
        case (state_i.phase)
          PH_ST1: begin
            nxt.scl[state_i.bus] = 1'b1;
            nxt.phase = PH_ST2;
          end
          PH_ST2: begin
            nxt.sda[state_i.bus] = 1'b0;
            nxt.phase = PH_ST3;
          end
          PH_ST3: begin
            nxt.scl[state_i.bus] = 1'b0;
            nxt.phase = PH_ST4;
          end
          PH_SP1: begin
            nxt.sda[state_i.bus] = 1'b0;
            nxt.phase = PH_SP2;
          end
          PH_SP2: begin
            nxt.scl[state_i.bus] = 1'b1;
            nxt.phase = PH_SP3;
          end
          PH_SP3: begin
            nxt.sda[state_i.bus] = 1'b1;
            timeout  = (state_i.cmd == MODE_WAIT_ACK);
            adv_done = 1'b1;
          end
          PH_TX_HI: begin
            nxt.sda[state_i.bus] = state_i.shift[7];
            nxt.shift = {state_i.shift[6:0], 1'b0};
            nxt.scl[state_i.bus] = 1'b1;
            nxt.phase = PH_TX_LO;
          end
          PH_TX_LO: begin
            nxt.scl[state_i.bus] = 1'b0;
            nxt.bit_count = cnt_inc;
            nxt.phase = (cnt_inc >= BITS_PER_BYTE) ? PH_TX_END : PH_TX_HI;
          end
          PH_RX_LO: begin
            nxt.scl[state_i.bus] = 1'b0;
            nxt.phase = PH_RX_HI;
          end
          PH_RX_HI: begin
            nxt.scl[state_i.bus] = 1'b1;
            nxt.phase = PH_RX_SMP;
          end
          PH_RX_SMP: begin
            nxt.shift = {state_i.shift[6:0], samp_bit};
            nxt.bit_count = cnt_inc;
            nxt.scl[state_i.bus] = 1'b0;
            if (cnt_inc >= BITS_PER_BYTE) begin
              nxt.drv[state_i.bus] = 1'b1;
              nxt.phase = PH_AK1;
            end else begin
              nxt.phase = PH_RX_HI;
            end
          end
          PH_AK1: begin
            nxt.sda[state_i.bus] = ~state_i.ack_choice;
            nxt.phase = PH_AK2;
          end
          PH_AK2: begin
            nxt.scl[state_i.bus] = 1'b1;
            nxt.phase = PH_AK3;
          end
          PH_AK3: begin
            nxt.scl[state_i.bus] = 1'b0;
            rx_valid = 1'b1;
            adv_done = 1'b1;
          end
          PH_WA: begin
            if (!samp_bit) begin
              nxt.scl[state_i.bus] = 1'b0;
              adv_done = 1'b1;
            end else if (state_i.wait_count >= limit_i) begin
              nxt.drv[state_i.bus] = 1'b1;
              nxt.scl[state_i.bus] = 1'b0;
              nxt.phase = PH_SP1;
            end else begin
              nxt.wait_count = state_i.wait_count + 8'd1;
            end
          end
          default: begin
            adv_done = 1'b1;
          end
        endcase
        if (adv_done) begin
          done = 1'b1;
          nxt.phase = PH_IDLE;
        end
      end else if (item_i.mode != MODE_TICK) begin
        if ({1'b0, item_i.bus_select} >= 3'(BUS_COUNT)) begin
          done = 1'b1;
        end else begin
          nxt.bus = item_i.bus_select;
          nxt.cmd = item_i.mode;
          nxt.bit_count = 4'd0;
          case (item_i.mode)
            MODE_START: begin
              nxt.drv[item_i.bus_select] = 1'b1;
              nxt.sda[item_i.bus_select] = 1'b1;
              nxt.phase = PH_ST1;
            end
            MODE_STOP: begin
              nxt.drv[item_i.bus_select] = 1'b1;
              nxt.scl[item_i.bus_select] = 1'b0;
              nxt.phase = PH_SP1;
            end
            MODE_SEND: begin
              nxt.drv[item_i.bus_select] = 1'b1;
              nxt.scl[item_i.bus_select] = 1'b0;
              nxt.shift = item_i.tx_byte;
              nxt.phase = PH_TX_HI;
            end
            MODE_READ: begin
              nxt.drv[item_i.bus_select] = 1'b0;
              nxt.shift = 8'd0;
              nxt.ack_choice = item_i.give_ack;
              nxt.phase = PH_RX_LO;
            end
            default: begin
              nxt.drv[item_i.bus_select] = 1'b0;
              nxt.scl[item_i.bus_select] = 1'b1;
              nxt.wait_count = 8'd0;
              nxt.phase = PH_WA;
            end
          endcase
        end
      end
    end
  end

  assign state_o = nxt;

  always_comb begin
    result_o.scl_lines   = nxt.scl;
    result_o.sda_lines   = nxt.sda;
    result_o.sda_enable  = nxt.drv;
    result_o.busy_res    = (nxt.phase != PH_IDLE);
    result_o.done_res    = done;
    result_o.rx_byte     = rx_valid ? nxt.shift : 8'd0;
    result_o.ack_timeout = timeout;
    result_o.refused     = refused;
  end

endmodule

// File: src/four_bus_i2c_master_sequencer.sv
// ----------------------------------------------------------------------------
// Four-bus I2C master sequencer
// Bit-banged I2C master for four buses, advanced at most one phase per beat.
// ----------------------------------------------------------------------------
// Every input beat, tick or command, yields exactly one result beat carrying
// the SCL, SDA and SDA-enable levels of all four buses after that beat. The
// block takes one beat per clock unless stalled. Each result is registered
// in the output register, or in the one-entry skid register while the
// output is stalled, so a new beat gets in while a result is stalled and
// the input stalls only when both hold results. The ACK timeout limit is
// written through the configuration port, which is always ready.
module four_bus_i2c_master_sequencer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  i2cms_pkg::item_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output i2cms_pkg::result_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_data_i
);
  import i2cms_pkg::*;

`include "four_bus_i2c_master_sequencer_macros.svh"

  state_t     state_q;
  state_t     state_d;
  result_t    res_d;
  result_t    out_q;
  result_t    skid_q;
  logic       out_valid_q;
  logic       skid_valid_q;
  logic [7:0] limit_q;
  logic       in_fire;
  logic       out_free;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_valid_q;
  assign in_fire     = in_valid_i & ~skid_valid_q;
  assign out_free    = ~out_valid_q | ~out_stall_i;

  i2cms_step u_step (
    .state_i  (state_q),
    .item_i   (in_data_i),
    .limit_i  (limit_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_RESET;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_fire) begin
        out_q <= res_d;
      end
    end else if (in_fire) begin
      skid_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `I2CMS_ASSERT_SAME(skid_needs_out_a, skid_valid_q, out_valid_q)
  `I2CMS_ASSERT_NEXT(skid_fills_a, in_fire && out_valid_q && out_stall_i, skid_valid_q)
  `I2CMS_ASSERT_NEXT(skid_drains_a, skid_valid_q && !out_stall_i, out_valid_q && (out_q == $past(skid_q)))

endmodule

// File: tb/sv/tb_four_bus_i2c_master_sequencer.sv
// ----------------------------------------------------------------------------
// Testbench for the four-bus I2C master sequencer
// Drives tick and command beats, predicts the line levels and flags of every
// result beat with a local copy of the sequencer, and checks each result in
// order. A short directed table comes first, then random transfers under
// several ACK timeout limits, most with random idling and two-sided stalls.
// ----------------------------------------------------------------------------
module tb_four_bus_i2c_master_sequencer;
  import i2cms_pkg::*;

  localparam logic [2:0] MODE_BAD_LO = 3'd6;
  localparam logic [2:0] MODE_BAD_HI = 3'd7;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_BEATS = 150;
  localparam int PHASE_COUNT = 7;
  localparam int DIR_COUNT = 21;

  localparam result_t AT_REST = '{4'hF, 4'hF, 4'hF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0};
  localparam result_t START_B3 = '{4'hF, 4'hF, 4'hF, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0};
  localparam result_t NONE = '0;

  typedef struct packed {
    logic    is_cfg;
    item_t   beat;
    logic    typed;
    result_t want;
  } row_t;

  localparam row_t DIRECTED [DIR_COUNT] = '{
    '{1'b0, '{MODE_TICK, 2'd0, 8'h00, 1'b0, 4'h0}, 1'b1, AT_REST},
    '{1'b0, '{MODE_BAD_LO, 2'd3, 8'hFF, 1'b1, 4'hF}, 1'b1, AT_REST},
    '{1'b0, '{MODE_BAD_HI, 2'd0, 8'h00, 1'b0, 4'h0}, 1'b1, AT_REST},
    '{1'b0, '{MODE_START, 2'd3, 8'hFF, 1'b1, 4'hF}, 1'b1, START_B3},
    '{1'b0, '{MODE_TICK, 2'd0, 8'h00, 1'b0, 4'h0}, 1'b0, NONE},
    '{1'b0, '{MODE_SEND, 2'd0, 8'hA5, 1'b0, 4'h0}, 1'b0, NONE},
    '{1'b0, '{MODE_TICK, 2'd1, 8'h00, 1'b0, 4'h5}, 1'b0, NONE},
    '{1'b0, '{MODE_TICK, 2'd2, 8'h00, 1'b1, 4'hA}, 1'b0, NONE},
    '{1'b0, '{MODE_STOP, 2'd0, 8'h00, 1'b0, 4'h0}, 1'b0, NONE},
    '{1'b0, '{MODE_TICK, 2'd0, 8'h00, 1'b0, 4'h0}, 1'b0, NONE},
    '{1'b0, '{MODE_TICK, 2'd0, 8'h00, 1'b0, 4'hF}, 1'b0, NONE},
    '{1'b0, '{MODE_TICK, 2'd0, 8'h00, 1'b0, 4'h0}, 1'b0, NONE},
    '{1'b0, '{MODE_WAIT_ACK, 2'd1, 8'h00, 1'b0, 4'hF}, 1'b0, NONE},
    '{1'b0, '{MODE_TICK, 2'd0, 8'h00, 1'b0, 4'hD}, 1'b0, NONE},
    '{1'b1, '{MODE_TICK, 2'd0, 8'h00, 1'b0, 4'h0}, 1'b0, NONE},
    '{1'b0, '{MODE_WAIT_ACK, 2'd2, 8'h00, 1'b0, 4'hF}, 1'b0, NONE},
    '{1'b0, '{MODE_TICK, 2'd0, 8'h00, 1'b0, 4'hF}, 1'b0, NONE},
    '{1'b0, '{MODE_TICK, 2'd0, 8'h00, 1'b0, 4'hF}, 1'b0, NONE},
    '{1'b0, '{MODE_TICK, 2'd0, 8'h00, 1'b0, 4'hF}, 1'b0, NONE},
    '{1'b0, '{MODE_TICK, 2'd0, 8'h00, 1'b0, 4'hF}, 1'b0, NONE},
    '{1'b1, '{MODE_TICK, 2'd0, 8'hFF, 1'b0, 4'h0}, 1'b0, NONE}
  };

  localparam logic [7:0] PHASE_LIMIT [PHASE_COUNT] = '{
    8'd1, 8'd0, 8'd255, 8'd7, 8'd250, 8'd2, 8'd3
  };

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    in_valid_i = 1'b0;
  logic    in_stall_o;
  item_t   in_data_i = '0;
  logic    out_valid_o;
  logic    out_stall_i = 1'b0;
  result_t out_data_o;
  logic    cfg_valid_i = 1'b0;
  logic    cfg_ready_o;
  logic    [7:0] cfg_data_i = 8'd0;

  four_bus_i2c_master_sequencer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Local copy of the sequencer state and the timeout limit.
  logic   [3:0] scl_q = 4'hF;
  logic   [3:0] sda_q = 4'hF;
  logic   [3:0] drv_q = 4'hF;
  phase_e       ph = PH_IDLE;
  logic   [2:0] cmd_q = 3'd0;
  logic   [1:0] bus_q = 2'd0;
  logic   [3:0] nbits = 4'd0;
  logic   [7:0] shreg = 8'd0;
  logic   [7:0] wcnt = 8'd0;
  logic         ackc = 1'b0;
  logic   [7:0] lim = LIMIT_RESET;

  result_t pending_lines[$];
  int      errs = 0;
  int      fed = 0;
  int      cycles = 0;
  bit      idle_on = 1'b0;
  bit      hold_req = 1'b0;

  function automatic result_t bus_step(input item_t it);
    result_t r;
    logic    bitv;
    logic    fin;
    logic    rxv;
    logic    tmo;
    logic    refd;
    bitv = it.sda_sampled[bus_q];
    fin = 1'b0;
    rxv = 1'b0;
    tmo = 1'b0;
    refd = 1'b0;
    if (it.mode <= MODE_WAIT_ACK) begin
      if (ph != PH_IDLE) begin
        if (it.mode != MODE_TICK) refd = 1'b1;
        case (ph)
          PH_ST1: begin
            scl_q[bus_q] = 1'b1;
            ph = PH_ST2;
          end
          PH_ST2: begin
            sda_q[bus_q] = 1'b0;
            ph = PH_ST3;
          end
          PH_ST3: begin
            scl_q[bus_q] = 1'b0;
            ph = PH_ST4;
          end
          PH_SP1: begin
            sda_q[bus_q] = 1'b0;
            ph = PH_SP2;
          end
          PH_SP2: begin
            scl_q[bus_q] = 1'b1;
            ph = PH_SP3;
          end
          PH_SP3: begin
            sda_q[bus_q] = 1'b1;
            tmo = (cmd_q == MODE_WAIT_ACK);
            fin = 1'b1;
          end
          PH_TX_HI: begin
            sda_q[bus_q] = shreg[7];
            shreg = shreg << 1;
            scl_q[bus_q] = 1'b1;
            ph = PH_TX_LO;
          end
          PH_TX_LO: begin
            scl_q[bus_q] = 1'b0;
            nbits = nbits + 4'd1;
            ph = (nbits >= BITS_PER_BYTE) ? PH_TX_END : PH_TX_HI;
          end
          PH_RX_LO: begin
            scl_q[bus_q] = 1'b0;
            ph = PH_RX_HI;
          end
          PH_RX_HI: begin
            scl_q[bus_q] = 1'b1;
            ph = PH_RX_SMP;
          end
          PH_RX_SMP: begin
            shreg = {shreg[6:0], bitv};
            nbits = nbits + 4'd1;
            scl_q[bus_q] = 1'b0;
            if (nbits >= BITS_PER_BYTE) begin
              drv_q[bus_q] = 1'b1;
              ph = PH_AK1;
            end else begin
              ph = PH_RX_HI;
            end
          end
          PH_AK1: begin
            sda_q[bus_q] = ~ackc;
            ph = PH_AK2;
          end
          PH_AK2: begin
            scl_q[bus_q] = 1'b1;
            ph = PH_AK3;
          end
          PH_AK3: begin
            scl_q[bus_q] = 1'b0;
            rxv = 1'b1;
            fin = 1'b1;
          end
          PH_WA: begin
            if (!bitv) begin
              scl_q[bus_q] = 1'b0;
              fin = 1'b1;
            end else if (wcnt >= lim) begin
              drv_q[bus_q] = 1'b1;
              scl_q[bus_q] = 1'b0;
              ph = PH_SP1;
            end else begin
              wcnt = wcnt + 8'd1;
            end
          end
          default: fin = 1'b1;
        endcase
        if (fin) ph = PH_IDLE;
      end else if (it.mode != MODE_TICK) begin
        bus_q = it.bus_select;
        cmd_q = it.mode;
        nbits = 4'd0;
        case (it.mode)
          MODE_START: begin
            drv_q[bus_q] = 1'b1;
            sda_q[bus_q] = 1'b1;
            ph = PH_ST1;
          end
          MODE_STOP: begin
            drv_q[bus_q] = 1'b1;
            scl_q[bus_q] = 1'b0;
            ph = PH_SP1;
          end
          MODE_SEND: begin
            drv_q[bus_q] = 1'b1;
            scl_q[bus_q] = 1'b0;
            shreg = it.tx_byte;
            ph = PH_TX_HI;
          end
          MODE_READ: begin
            drv_q[bus_q] = 1'b0;
            shreg = 8'd0;
            ackc = it.give_ack;
            ph = PH_RX_LO;
          end
          default: begin
            drv_q[bus_q] = 1'b0;
            scl_q[bus_q] = 1'b1;
            wcnt = 8'd0;
            ph = PH_WA;
          end
        endcase
      end
    end
    r.scl_lines = scl_q;
    r.sda_lines = sda_q;
    r.sda_enable = drv_q;
    r.busy_res = (ph != PH_IDLE);
    r.done_res = fin;
    r.rx_byte = rxv ? shreg : 8'd0;
    r.ack_timeout = tmo;
    r.refused = refd;
    return r;
  endfunction

  // Entered and left at a falling edge.
  task automatic push_beat(input item_t it, input logic typed, input result_t want);
    int      gap;
    result_t r;
    gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 10) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (ph != PH_IDLE || (it.mode != MODE_TICK && it.mode <= MODE_WAIT_ACK)) fed++;
    r = bus_step(it);
    pending_lines.push_back(typed ? want : r);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_lines.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [7:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    lim = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // One command and the ticks that carry it to its end, with the odd refused
  // command or ignored beat mixed in.
  task automatic drive_transfer();
    item_t cmd;
    item_t tk;
    int    style;
    int    pick;
    cmd.mode = 3'($urandom_range(MODE_START, MODE_WAIT_ACK));
    cmd.bus_select = 2'($urandom);
    cmd.tx_byte = 8'($urandom);
    cmd.give_ack = 1'($urandom);
    cmd.sda_sampled = 4'($urandom);
    style = $urandom_range(0, 3);
    if (cmd.mode == MODE_WAIT_ACK && lim > 8'd16 && style == 2 && $urandom_range(0, 5) != 0)
      style = 0;
    push_beat(cmd, 1'b0, NONE);
    while (ph != PH_IDLE) begin
      tk.bus_select = 2'($urandom);
      tk.tx_byte = 8'($urandom);
      tk.give_ack = 1'($urandom);
      case (style)
        2: tk.sda_sampled = 4'hF;
        3: tk.sda_sampled = 4'h0;
        default: tk.sda_sampled = 4'($urandom);
      endcase
      pick = $urandom_range(0, 19);
      if (pick == 0) tk.mode = 3'($urandom_range(MODE_START, MODE_WAIT_ACK));
      else if (pick == 1) tk.mode = 3'($urandom_range(MODE_BAD_LO, MODE_BAD_HI));
      else tk.mode = MODE_TICK;
      push_beat(tk, 1'b0, NONE);
    end
  endtask

  always begin
    @(negedge clk_i);
    if (hold_req) begin
      out_stall_i <= 1'b1;
      repeat (60) @(negedge clk_i);
      out_stall_i <= 1'b0;
      hold_req = 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_stall_i <= 1'b1;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  function automatic void cmp_field(input string fname, input logic [7:0] w,
                                    input logic [7:0] g);
    if (w !== g) begin
      errs++;
      $display("%0t: %s expected %h got %h", $time, fname, w, g);
    end
  endfunction

  always @(posedge clk_i) begin
    result_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_lines.size() == 0) begin
        errs++;
        $display("%0t: unexpected result beat expected none got %h", $time, out_data_o);
      end else begin
        w = pending_lines.pop_front();
        cmp_field("scl_lines", 8'(w.scl_lines), 8'(out_data_o.scl_lines));
        cmp_field("sda_lines", 8'(w.sda_lines), 8'(out_data_o.sda_lines));
        cmp_field("sda_enable", 8'(w.sda_enable), 8'(out_data_o.sda_enable));
        cmp_field("busy_res", 8'(w.busy_res), 8'(out_data_o.busy_res));
        cmp_field("done_res", 8'(w.done_res), 8'(out_data_o.done_res));
        cmp_field("rx_byte", w.rx_byte, out_data_o.rx_byte);
        cmp_field("ack_timeout", 8'(w.ack_timeout), 8'(out_data_o.ack_timeout));
        cmp_field("refused", 8'(w.refused), 8'(out_data_o.refused));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_four_bus_i2c_master_sequencer: done, errors");
      $finish;
    end
  end

  initial begin
    item_t noise;
    int    target;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DIR_COUNT; i++) begin
      if (DIRECTED[i].is_cfg) begin
        drain();
        write_limit(DIRECTED[i].beat.tx_byte);
      end else begin
        push_beat(DIRECTED[i].beat, DIRECTED[i].typed, DIRECTED[i].want);
      end
    end

    for (int k = 0; k < PHASE_COUNT; k++) begin
      drain();
      write_limit(PHASE_LIMIT[k]);
      idle_on = (k != 1) && (k != PHASE_COUNT - 1);
      if (k == 2) hold_req = 1'b1;
      target = fed + PHASE_BEATS;
      while (fed < target) begin
        if ($urandom_range(0, 5) == 0) begin
          noise.mode = ($urandom_range(0, 1) == 0) ? MODE_TICK
                                                    : 3'($urandom_range(MODE_BAD_LO,
                                                                        MODE_BAD_HI));
          noise.bus_select = 2'($urandom);
          noise.tx_byte = 8'($urandom);
          noise.give_ack = 1'($urandom);
          noise.sda_sampled = 4'($urandom);
          push_beat(noise, 1'b0, NONE);
        end else begin
          drive_transfer();
        end
      end
    end

    drain();
    repeat (4) @(posedge clk_i);
    if (errs == 0 && pending_lines.size() == 0) begin
      $display("tb_four_bus_i2c_master_sequencer: done, clean");
    end else begin
      $display("tb_four_bus_i2c_master_sequencer: done, errors");
    end
    $finish;
  end

endmodule

// File: four_bus_i2c_master_sequencer.f
+incdir+src
src/i2cms_pkg.sv
src/i2cms_step.sv
src/four_bus_i2c_master_sequencer.sv
tb/sv/tb_four_bus_i2c_master_sequencer.sv
